@@ sv/ppst_pkg.sv @@
// Package for the preset position stepper: command codes, field widths and
// reset constants. No dependencies.

package ppst_pkg;

    localparam int POS_W = 16;
    localparam int TOL_W = 15;
    localparam int SEL_IN_W = 5;
    localparam int OUT_IDX_W = 5;
    localparam int OUT_CNT_W = 5;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam logic [TOL_W-1:0] TOL_RESET = 15'd25;
    localparam logic [TOL_W-1:0] TOL_MIN = 15'd1;

    typedef logic [1:0] cmd_t;

    localparam cmd_t CMD_CLEAR = 2'd0;
    localparam cmd_t CMD_ADD = 2'd1;
    localparam cmd_t CMD_SELECT = 2'd2;
    localparam cmd_t CMD_STEP = 2'd3;

    typedef logic signed [POS_W-1:0] pos_t;

endpackage

@@ sv/preset_position_stepper_top.sv @@
// Preset position stepper: top level with command sequencer and scan logic.
// Depends on ppst_pkg and ppst_ram (preset table storage).
//
// Usage:
//   s_* channel: one beat per command (clear, add, select, step). s_tready
//   is high only while the sequencer is idle; it does not wait for the
//   result register, so a new beat is taken while a result is still pending.
//   m_* channel: exactly one result beat per command, held in an output
//   register until the receiver takes it. A stalled receiver only stops the
//   sequencer when the next result is ready and the register is still full.
//   cfg_* channel: writes the tolerance register (0 is stored as 1); always
//   ready. Write it only while the block is idle; this is not enforced.
// Sequencing:
//   clear, add and select go straight to the fetch and data states.
//   step scans the table through the memory's single read port, one entry a
//   cycle: a window scan, then, if it finds no entry, an above scan.
// Reset (aresetn low, synchronous): count 0, selected index 0, tolerance 25,
//   no result pending. Table contents are not cleared; only entries below
//   the count are ever read.

module preset_position_stepper_top #(
    parameter int MAX_PRESETS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] position, [16] direction_up, [21:17] select_index, [23:22] zero
    input  logic [23:0] s_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [4:0] result_index, [20:5] target_position, [25:21] preset_count,
    // [31:26] zero
    output logic [31:0] m_tdata,
    // [0] add_dropped
    output logic [0:0]  m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [14:0] cfg_data
);

    localparam int IDX_W = (MAX_PRESETS > 1) ? $clog2(MAX_PRESETS) : 1;
    localparam int CNT_W = $clog2(MAX_PRESETS + 1);
    localparam int SEL_W = IDX_W + 1;
    localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
    localparam int POS_W = ppst_pkg::POS_W;
    localparam int TOL_W = ppst_pkg::TOL_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN1 = 3'd1;
    localparam logic [2:0] ST_SCAN2 = 3'd2;
    localparam logic [2:0] ST_FETCH = 3'd3;
    localparam logic [2:0] ST_DATA = 3'd4;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PRESETS);
    localparam logic signed [SEL_W-1:0] SEL_NONE = '1;

    logic [2:0]              state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [SEL_W-1:0] sel_reg, sel_next;
    logic [TOL_W-1:0]        tol_reg, tol_next;
    ppst_pkg::pos_t          pos_reg, pos_next;
    logic                    up_reg, up_next;
    logic                    drop_reg, drop_next;
    logic [CNT_W-1:0]        scan_idx_reg, scan_idx_next;
    logic                    rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]        rd_idx_reg, rd_idx_next;

    logic                    m_valid_reg, m_valid_next;
    logic [31:0]             m_data_reg, m_data_next;
    logic                    m_drop_reg, m_drop_next;

    logic                    s_accept;
    ppst_pkg::cmd_t          in_cmd;
    ppst_pkg::pos_t          in_pos;
    logic                    in_up;
    logic signed [4:0]       in_sel;
    logic                    in_sel_ok;

    logic                    ram_we;
    logic                    ram_re;
    logic [IDX_W-1:0]        ram_raddr;
    logic [POS_W-1:0]        ram_q;
    ppst_pkg::pos_t          entry;

    logic signed [POS_W:0]   diff;
    logic [POS_W:0]          abs_diff;
    logic                    hit_win;
    logic                    hit_above;
    logic                    last_entry;
    logic                    in_scan;
    logic                    scan_leave;
    logic                    issue;
    logic                    sel_ok;
    logic                    out_load;
    ppst_pkg::pos_t          target;
    logic signed [SEL_W-1:0] ri_sel;
    logic signed [SEL_W-1:0] ri_up;
    logic signed [SEL_W-1:0] ri_dn;
    logic signed [ppst_pkg::OUT_IDX_W-1:0] out_idx;

    assign in_cmd = s_tuser;
    assign in_pos = s_tdata[15:0];
    assign in_up = s_tdata[16];
    assign in_sel = s_tdata[21:17];
    assign in_sel_ok = !in_sel[4] && (CMP_W'(in_sel[3:0]) < CMP_W'(count_reg));

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;
    assign m_tuser = m_drop_reg;

    assign ram_we = s_accept && (in_cmd == ppst_pkg::CMD_ADD) && (count_reg != CNT_MAX);

    ppst_ram #(
        .WIDTH (POS_W),
        .DEPTH (MAX_PRESETS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (in_pos),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    // Scan evaluation on the entry that came back from the previous read
    assign entry = ram_q;
    assign diff = (POS_W+1)'(entry) - (POS_W+1)'(pos_reg);
    assign abs_diff = diff[POS_W] ? (POS_W+1)'(-diff) : (POS_W+1)'(diff);
    assign hit_win = abs_diff < (POS_W+1)'(tol_reg);
    assign hit_above = entry > pos_reg;
    assign last_entry = (CNT_W'(rd_idx_reg) + CNT_W'(1)) == count_reg;

    assign ri_sel = SEL_W'(rd_idx_reg);
    assign ri_up = ri_sel + SEL_W'(1);
    assign ri_dn = ri_sel - SEL_W'(1);

    assign in_scan = (state_reg == ST_SCAN1) || (state_reg == ST_SCAN2);
    assign scan_leave = in_scan && rd_vld_reg
        && (last_entry || ((state_reg == ST_SCAN1) ? hit_win : hit_above));
    assign issue = in_scan && !scan_leave && (scan_idx_reg < count_reg);

    assign sel_ok = !sel_reg[SEL_W-1] && (CNT_W'(sel_reg[IDX_W-1:0]) < count_reg);
    assign ram_re = issue || ((state_reg == ST_FETCH) && sel_ok);
    assign ram_raddr = (state_reg == ST_FETCH) ? sel_reg[IDX_W-1:0]
                                               : scan_idx_reg[IDX_W-1:0];

    assign target = rd_vld_reg ? ppst_pkg::pos_t'(ram_q) : '0;
    assign out_load = (state_reg == ST_DATA) && (!m_valid_reg || m_tready);
    assign out_idx = ppst_pkg::OUT_IDX_W'(sel_reg);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        sel_next = sel_reg;
        pos_next = pos_reg;
        up_next = up_reg;
        drop_next = drop_reg;
        scan_idx_next = scan_idx_reg;
        rd_vld_next = 1'b0;
        rd_idx_next = rd_idx_reg;
        tol_next = tol_reg;

        if (cfg_valid) begin
            tol_next = (cfg_data == '0) ? ppst_pkg::TOL_MIN : cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    pos_next = in_pos;
                    up_next = in_up;
                    drop_next = 1'b0;
                    state_next = ST_FETCH;
                    case (in_cmd)
                        ppst_pkg::CMD_CLEAR: begin
                            count_next = '0;
                            sel_next = '0;
                        end
                        ppst_pkg::CMD_ADD: begin
                            if (count_reg == CNT_MAX) begin
                                drop_next = 1'b1;
                            end else begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        ppst_pkg::CMD_SELECT: begin
                            sel_next = in_sel_ok ? SEL_W'(in_sel[3:0]) : SEL_NONE;
                        end
                        default: begin
                            if (count_reg == '0) begin
                                sel_next = SEL_NONE;
                            end else begin
                                scan_idx_next = '0;
                                state_next = ST_SCAN1;
                            end
                        end
                    endcase
                end
            end
            ST_SCAN1: begin
                if (rd_vld_reg && hit_win) begin
                    if (up_reg) begin
                        sel_next = last_entry ? ri_sel : ri_up;
                    end else begin
                        sel_next = (rd_idx_reg == '0) ? SEL_W'(0) : ri_dn;
                    end
                    state_next = ST_FETCH;
                end else if (rd_vld_reg && last_entry) begin
                    // window pass found nothing: start the above-position pass
                    scan_idx_next = '0;
                    state_next = ST_SCAN2;
                end
            end
            ST_SCAN2: begin
                if (rd_vld_reg && hit_above) begin
                    if (up_reg) begin
                        sel_next = ri_sel;
                    end else begin
                        sel_next = (rd_idx_reg == '0) ? SEL_NONE : ri_dn;
                    end
                    state_next = ST_FETCH;
                end else if (rd_vld_reg && last_entry) begin
                    sel_next = up_reg ? SEL_NONE : ri_sel;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                rd_vld_next = sel_ok;
                state_next = ST_DATA;
            end
            ST_DATA: begin
                // hold the read data until the result register frees up
                rd_vld_next = rd_vld_reg;
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (issue) begin
            rd_vld_next = 1'b1;
            rd_idx_next = scan_idx_reg[IDX_W-1:0];
            scan_idx_next = scan_idx_reg + CNT_W'(1);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next = m_data_reg;
        m_drop_next = m_drop_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next = {6'd0, ppst_pkg::OUT_CNT_W'(count_reg), target, out_idx};
            m_drop_next = drop_reg;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            sel_reg <= '0;
            tol_reg <= ppst_pkg::TOL_RESET;
            rd_vld_reg <= 1'b0;
            scan_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            sel_reg <= sel_next;
            tol_reg <= tol_next;
            rd_vld_reg <= rd_vld_next;
            scan_idx_reg <= scan_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        up_reg <= up_next;
        drop_reg <= drop_next;
        rd_idx_reg <= rd_idx_next;
        m_data_reg <= m_data_next;
        m_drop_reg <= m_drop_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX)
        else $error("preset count above table depth");

    a_sel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (sel_reg == SEL_NONE) || (sel_reg == '0) || sel_ok)
        else $error("selected index outside table");

    a_tol_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        tol_reg != '0)
        else $error("tolerance is zero");

    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        in_scan |-> (count_reg != '0))
        else $error("scan running on empty table");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg != ST_IDLE))
        else $error("sequencer idle right after accepting a beat");
`endif

endmodule

@@ sv/ppst_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.

module ppst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
